@@ rtl/core/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned PIX_W          = 24;
  localparam int unsigned CH_W           = 8;
  localparam int unsigned CFG_DATA_W     = 11;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // squared magnitude at or above this rounds past 255
  localparam logic [20:0] SAT_THRESH = 21'd65281;

  typedef logic [PIX_W-1:0] pix_t;

  // window indexed [row][column], row 0 is the upper row
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // which neighbors lie inside the frame
  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } mask_t;

endpackage

@@ rtl/core/sem_line_store.sv @@
// ----------------------------------------------------------------------------
// sem_line_store
// Line store memory holding the upper and middle rows side by side, with a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module sem_line_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [2*sem_pkg::PIX_W-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [2*sem_pkg::PIX_W-1:0] wr_data_i,
  output logic                     clr_busy_o
);
  import sem_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = 2 * PIX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          clr_busy_q, clr_busy_d;

  // clearing pass, one entry a cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ rtl/core/sem_magnitude.sv @@
// ----------------------------------------------------------------------------
// sem_magnitude
// Per-channel Sobel gradients, squared sum and iterative rounded square root
// saturated at 255.
// ----------------------------------------------------------------------------
module sem_magnitude (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sem_pkg::win_t  win_i,
  input  sem_pkg::mask_t mask_i,
  output logic           done_o,
  output sem_pkg::pix_t  result_o
);
  import sem_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SUM  = 2'd1;
  localparam logic [1:0] M_ITER = 2'd2;
  localparam logic [1:0] M_RND  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       done_q, done_d;

  logic [2:0][19:0] sqx_q, sqy_q;
  logic [2:0][20:0] sum_q;
  logic [2:0][7:0]  root_q;
  logic [2:0][7:0]  res_q;

  logic [2:0][19:0] sqx_d, sqy_d;
  logic [2:0][7:0]  root_d;
  logic [2:0][7:0]  res_d;

  // gradient terms and squares
  always_comb begin
    logic [2:0][2:0][7:0] t;
    logic [9:0]           px, nx, py, ny;
    logic signed [10:0]   gx, gy;
    logic signed [21:0]   px2, py2;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          t[r][c] = win_i[r][c][PIX_W-1-CH_W*ch -: CH_W];
          if ((r == 0 && !mask_i.up) || (r == 2 && !mask_i.down) ||
              (c == 0 && !mask_i.left) || (c == 2 && !mask_i.right)) begin
            t[r][c] = '0;
          end
        end
      end
      px = 10'(t[0][2]) + {1'b0, t[1][2], 1'b0} + 10'(t[2][2]);
      nx = 10'(t[0][0]) + {1'b0, t[1][0], 1'b0} + 10'(t[2][0]);
      py = 10'(t[2][0]) + {1'b0, t[2][1], 1'b0} + 10'(t[2][2]);
      ny = 10'(t[0][0]) + {1'b0, t[0][1], 1'b0} + 10'(t[0][2]);
      gx = signed'({1'b0, px}) - signed'({1'b0, nx});
      gy = signed'({1'b0, py}) - signed'({1'b0, ny});
      px2 = gx * gx;
      py2 = gy * gy;
      sqx_d[ch] = px2[19:0];
      sqy_d[ch] = py2[19:0];
    end
  end

  // one root bit per step, then rounding
  always_comb begin
    logic [7:0]  tb;
    logic [15:0] tt;
    logic [15:0] nn;
    logic [20:0] rem;
    for (int ch = 0; ch < 3; ch++) begin
      tb = root_q[ch] | (8'd1 << step_q);
      tt = tb * tb;
      root_d[ch] = ({5'b0, tt} <= sum_q[ch]) ? tb : root_q[ch];
      nn = root_q[ch] * root_q[ch];
      rem = sum_q[ch] - {5'b0, nn};
      if (sum_q[ch] >= SAT_THRESH) begin
        res_d[ch] = 8'd255;
      end else if (rem > {13'b0, root_q[ch]}) begin
        res_d[ch] = root_q[ch] + 1'b1;
      end else begin
        res_d[ch] = root_q[ch];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: begin
        if (start_i) state_d = M_SUM;
      end
      M_SUM: begin
        step_d  = 3'd7;
        state_d = M_ITER;
      end
      M_ITER: begin
        if (step_q == 3'd0) begin
          state_d = M_RND;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      M_RND: begin
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
    if (state_q == M_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch]  <= 21'(sqx_q[ch]) + 21'(sqy_q[ch]);
        root_q[ch] <= '0;
      end
    end
    if (state_q == M_ITER) begin
      root_q <= root_d;
    end
    if (state_q == M_RND) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = {res_q[0], res_q[1], res_q[2]};

endmodule

@@ rtl/core/sobel_edge_magnitude_rgb.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude per RGB channel, raster order.
// ----------------------------------------------------------------------------
// Each request is one pixel or one flush item; the result for a pixel leaves
// once its lower-right neighbor has arrived, and flush items drain the rest
// one per request. A request that gives no result passes through the line
// store read, then the window and line store update; one that gives a
// result also waits on the magnitude unit, whose square root produces one
// bit per cycle after the gradient and sum stages. A flush with nothing
// pending is taken without leaving the idle state. After reset the line
// store is cleared one entry a cycle, all MAX_WIDTH entries, during which
// no request is taken; configuration writes are taken at any time.
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [7:0]                     red_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_edge_o,
  output logic [7:0]                     green_edge_o,
  output logic [7:0]                     blue_edge_o,
  output logic                           frame_last_o
);
  import sem_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned EWW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned EHW = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_GO   = 3'd2;
  localparam logic [2:0] ST_MAG  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [CFG_DATA_W-1:0] fw_q, fh_q;
  logic [EWW-1:0]        w, full;
  logic [EHW-1:0]        h;

  logic [CW-1:0]  col_q, col_d, out_col_q, out_col_d, feed_q, feed_d;
  logic [RW-1:0]  row_q, row_d, out_row_q, out_row_d;
  logic [EWW-1:0] lag_q, lag_d, pend_q, pend_d;

  logic           in_req, work, emit, last;
  logic [CW-1:0]  j;
  mask_t          mask;

  logic           flush_q, emit_q, last_q;
  logic [CW-1:0]  j_q;
  pix_t           pix_q;
  mask_t          mask_q;
  win_t           win_q;

  logic [2*PIX_W-1:0] rd_data;
  logic               clr_busy;
  logic               mag_done;
  pix_t               mag_res;

  logic               out_valid_q;
  pix_t               out_pix_q;
  logic               out_last_q;
  logic               out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= CFG_SIZE_RESET;
      fh_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (fw_q == '0) begin
      w = EWW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w = EWW'(MAX_WIDTH);
    end else begin
      w = EWW'(fw_q);
    end
    if (fh_q == '0) begin
      h = EHW'(1);
    end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
      h = EHW'(MAX_HEIGHT);
    end else begin
      h = EHW'(fh_q);
    end
    full = w + 1'b1;
  end

  assign in_stall_o = clr_busy || (state_q != ST_IDLE);
  assign in_req     = in_valid_i && !in_stall_o;

  // position bookkeeping for one request
  always_comb begin
    logic           restart;
    logic [EWW-1:0] lag1, pend1;
    logic [CW-1:0]  oc1;
    logic [RW-1:0]  or1;
    logic [EWW-1:0] col_inc, oc_inc, feed_inc;
    logic [EHW-1:0] row_inc, or_inc;
    logic [CW-1:0]  new_col, adv_col;
    logic [RW-1:0]  new_row, adv_row;

    restart = !action_i && (lag_q > pend_q);
    lag1    = restart ? '0 : lag_q;
    pend1   = restart ? '0 : pend_q;
    oc1     = restart ? col_q : out_col_q;
    or1     = restart ? row_q : out_row_q;
    work    = !action_i || (pend_q != '0);
    j       = action_i ? feed_q : col_q;
    emit    = lag1 >= full;

    col_inc = EWW'(col_q) + 1'b1;
    row_inc = EHW'(row_q) + 1'b1;
    new_col = (col_inc >= w) ? '0 : CW'(col_inc);
    new_row = row_q;
    if (col_inc >= w) new_row = (row_inc >= h) ? '0 : RW'(row_inc);

    oc_inc  = EWW'(oc1) + 1'b1;
    or_inc  = EHW'(or1) + 1'b1;
    adv_col = (oc_inc >= w) ? '0 : CW'(oc_inc);
    adv_row = or1;
    if (oc_inc >= w) adv_row = (or_inc >= h) ? '0 : RW'(or_inc);

    feed_inc = EWW'(feed_q) + 1'b1;

    mask.left  = oc1 != '0;
    mask.right = (oc_inc < w) && (j != '0);
    mask.up    = or1 != '0;
    mask.down  = or_inc < h;
    last       = (or_inc >= h) && (oc_inc >= w);

    col_d     = col_q;
    row_d     = row_q;
    feed_d    = feed_q;
    out_col_d = oc1;
    out_row_d = or1;
    lag_d     = lag1;
    pend_d    = pend1;
    if (!action_i) begin
      col_d  = new_col;
      row_d  = new_row;
      feed_d = new_col;
      if (emit) begin
        out_col_d = adv_col;
        out_row_d = adv_row;
      end else begin
        lag_d  = lag1 + 1'b1;
        pend_d = pend1 + 1'b1;
      end
    end else begin
      feed_d = (feed_inc >= w) ? '0 : CW'(feed_inc);
      if (emit) begin
        out_col_d = adv_col;
        out_row_d = adv_row;
        pend_d    = pend_q - 1'b1;
        if (pend_q == EWW'(1)) lag_d = '0;
      end else begin
        lag_d = lag_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      feed_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
      pend_q    <= '0;
    end else if (in_req && work) begin
      col_q     <= col_d;
      row_q     <= row_d;
      feed_q    <= feed_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
      pend_q    <= pend_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (in_req && work) begin
      flush_q <= action_i;
      emit_q  <= emit;
      last_q  <= last;
      j_q     <= j;
      pix_q   <= {red_in_i, green_in_i, blue_in_i};
      mask_q  <= mask;
    end
  end

  // line store, read at accept and written back in the update cycle; the
  // next read of any entry comes after that write, so no forwarding is needed
  sem_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_req && work),
    .rd_addr_i (j),
    .rd_data_o (rd_data),
    .wr_en_i   ((state_q == ST_UPD) && !flush_q),
    .wr_addr_i (j_q),
    .wr_data_i ({rd_data[PIX_W-1:0], pix_q}),
    .clr_busy_o(clr_busy)
  );

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (state_q == ST_UPD) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_data[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_data[PIX_W-1:0];
      win_q[2][2] <= flush_q ? '0 : pix_q;
    end
  end

  sem_magnitude u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_GO),
    .win_i   (win_q),
    .mask_i  (mask_q),
    .done_o  (mag_done),
    .result_o(mag_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // request sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_req && work) state_d = ST_UPD;
      ST_UPD:  state_d = emit_q ? ST_GO : ST_IDLE;
      ST_GO:   state_d = ST_MAG;
      ST_MAG:  if (mag_done) state_d = out_free ? ST_IDLE : ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ((state_q == ST_MAG) && mag_done) || (state_q == ST_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && (((state_q == ST_MAG) && mag_done) || (state_q == ST_OUT))) begin
      out_pix_q  <= mag_res;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_edge_o   = out_pix_q[23:16];
  assign green_edge_o = out_pix_q[15:8];
  assign blue_edge_o  = out_pix_q[7:0];
  assign frame_last_o = out_last_q;

  // checks
  a_pend_le_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= lag_q)
    else $error("pending count exceeds lag");

  a_done_in_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_done |-> (state_q == ST_MAG))
    else $error("magnitude done outside wait state");

  a_no_req_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (state_q == ST_IDLE))
    else $error("request in flight during line store clear");

endmodule
